### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define UER_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define UER_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Types, register indexes and constants of the echo ranger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

   localparam int COUNT_BITS_DEFAULT = 20;

   localparam int TIMEOUT_W  = 20;
   localparam int TRIGGER_W  = 8;
   localparam int PULSE_W    = 20;
   localparam int DIST_W     = 15;
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_LEVEL = 2'd3;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET      = 20'd1000000;
   localparam logic [TRIGGER_W-1:0] TRIGGER_HIGH_RESET = 8'd10;
   localparam logic [TRIGGER_W-1:0] TRIGGER_LOW_RESET  = 8'd2;
   localparam logic                 ACTIVE_LEVEL_RESET = 1'b1;

   // distance = floor(floor(width/2) * DIST_STEP / DIST_DIVISOR)
   localparam int DIST_STEP    = 10;
   localparam int DIST_DIVISOR = 291;
   localparam int REM_W        = $clog2(DIST_DIVISOR + DIST_STEP);

   localparam logic [PULSE_W-1:0] PULSE_MAX = '1;
   localparam logic [DIST_W-1:0]  DIST_MAX  = '1;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] timeout_us;
      logic [TRIGGER_W-1:0] trigger_high_us;
      logic [TRIGGER_W-1:0] trigger_low_us;
      logic                 active_level;
   } uer_cfg_type;

   typedef struct packed {
      logic               trigger_out;
      logic               busy_res;
      logic               done_res;
      logic               timed_out;
      logic [PULSE_W-1:0] pulse_us;
      logic [DIST_W-1:0]  distance_cm;
   } uer_result_type;

endpackage

`default_nettype wire

### rtl/uer_core.sv
// ----------------------------------------------------------------------------
// uer_core
// Sequencer state and per-tick next-state logic; distance kept as a running
// quotient and remainder updated while the pulse is counted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uer_core #(
   parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step_en,
   input  wire logic                   start_req,
   input  wire logic                   echo_level,
   input  wire uer_pkg::uer_cfg_type   cfg,
   output uer_pkg::uer_result_type     result
);
   import uer_pkg::*;

   localparam int LW = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_LOW   = 3'd1;
   localparam logic [2:0] PH_HIGH  = 3'd2;
   localparam logic [2:0] PH_WAIT  = 3'd3;
   localparam logic [2:0] PH_PULSE = 3'd4;

   localparam logic [REM_W-1:0] REM_STEP = REM_W'(DIST_STEP);
   localparam logic [REM_W-1:0] REM_DIV  = REM_W'(DIST_DIVISOR);

   logic [2:0]            phase_ff, phase_in;
   logic [TRIGGER_W-1:0]  trig_cnt_ff, trig_cnt_in;
   logic [COUNT_BITS-1:0] elapsed_ff, elapsed_in;
   logic [COUNT_BITS-1:0] width_ff, width_in;
   logic [COUNT_BITS-1:0] quot_ff, quot_in;
   logic [REM_W-1:0]      rem_ff, rem_in;

   logic                  emitted;
   logic                  over;
   logic [REM_W-1:0]      rem_sum;
   logic [LW-1:0]         limit;
   logic [LW-1:0]         width_ext;

   assign limit = (LW'(cfg.timeout_us) > LW'(CMAX)) ? LW'(CMAX) : LW'(cfg.timeout_us);

   always_comb begin
      phase_in    = phase_ff;
      trig_cnt_in = trig_cnt_ff;
      elapsed_in  = elapsed_ff;
      width_in    = width_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      emitted     = 1'b0;
      over        = 1'b0;
      rem_sum     = '0;
      width_ext   = '0;
      result      = '0;

      if (phase_in > PH_PULSE) begin
         phase_in = PH_IDLE;
      end

      if (phase_in == PH_IDLE && start_req) begin
         phase_in    = PH_LOW;
         trig_cnt_in = cfg.trigger_low_us;
      end

      if (phase_in == PH_LOW) begin
         if (trig_cnt_in == '0) begin
            phase_in    = PH_HIGH;
            trig_cnt_in = cfg.trigger_high_us;
         end else begin
            result.busy_res = 1'b1;
            trig_cnt_in     = trig_cnt_in - 1'b1;
            emitted         = 1'b1;
            if (trig_cnt_in == '0) begin
               phase_in    = PH_HIGH;
               trig_cnt_in = cfg.trigger_high_us;
            end
         end
      end

      if (!emitted && phase_in == PH_HIGH) begin
         if (trig_cnt_in == '0) begin
            phase_in   = PH_WAIT;
            elapsed_in = '0;
            width_in   = '0;
            quot_in    = '0;
            rem_in     = '0;
         end else begin
            result.busy_res    = 1'b1;
            result.trigger_out = 1'b1;
            trig_cnt_in        = trig_cnt_in - 1'b1;
            emitted            = 1'b1;
            if (trig_cnt_in == '0) begin
               phase_in   = PH_WAIT;
               elapsed_in = '0;
               width_in   = '0;
               quot_in    = '0;
               rem_in     = '0;
            end
         end
      end

      if (!emitted && (phase_in == PH_WAIT || phase_in == PH_PULSE)) begin
         over = LW'(elapsed_in) >= limit;
         if (elapsed_in != CMAX) begin
            elapsed_in = elapsed_in + 1'b1;
         end
         if (echo_level == cfg.active_level) begin
            phase_in = PH_PULSE;
            if (width_in != CMAX) begin
               // half width grows on every second tick
               if (width_in[0]) begin
                  rem_sum = rem_in + REM_STEP;
                  if (rem_sum >= REM_DIV) begin
                     rem_in  = rem_sum - REM_DIV;
                     quot_in = quot_in + 1'b1;
                  end else begin
                     rem_in = rem_sum;
                  end
               end
               width_in = width_in + 1'b1;
            end
            if (over) begin
               result.done_res  = 1'b1;
               result.timed_out = 1'b1;
            end else begin
               result.busy_res = 1'b1;
            end
         end else if (phase_in == PH_PULSE) begin
            result.done_res = 1'b1;
            width_ext       = LW'(width_in);
            result.pulse_us = (width_ext > LW'(PULSE_MAX)) ? PULSE_MAX
                                                           : width_ext[PULSE_W-1:0];
            result.distance_cm = (quot_in > COUNT_BITS'(DIST_MAX)) ? DIST_MAX
                                                                   : quot_in[DIST_W-1:0];
         end else if (over) begin
            result.done_res  = 1'b1;
            result.timed_out = 1'b1;
         end else begin
            result.busy_res = 1'b1;
         end
         if (result.done_res) begin
            phase_in   = PH_IDLE;
            elapsed_in = '0;
            width_in   = '0;
            quot_in    = '0;
            rem_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         trig_cnt_ff <= '0;
         elapsed_ff  <= '0;
         width_ff    <= '0;
         quot_ff     <= '0;
         rem_ff      <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         trig_cnt_ff <= trig_cnt_in;
         elapsed_ff  <= elapsed_in;
         width_ff    <= width_in;
         quot_ff     <= quot_in;
         rem_ff      <= rem_in;
      end
   end

endmodule

`default_nettype wire

### rtl/ultrasonic_echo_ranger_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_unit
// Trigger pulse sequencer and echo pulse width / distance measurement.
// ----------------------------------------------------------------------------
// Usage:
//   Each req_ item is one microsecond tick: a start request and the sampled
//   echo pin. Each item gives exactly one rsp_ item carrying the trigger pin
//   level, busy, done, timed_out, pulse width and distance in cm.
//   An item passes an input register, then the sequencer logic, then the
//   result register; rsp_valid rises when the item moves on from the input
//   register, which it does once the result register is empty or being taken.
//   Throughput is one item per cycle while rsp_ready is high, set by the
//   combinational sequencer update between the two registers.
//   When rsp_ready is low the result register holds and one more item is
//   taken into the input register; req_ready then drops until the result
//   is taken.
//   Reset clears both valid flags, returns the sequencer to idle and loads the
//   register defaults (timeout 1000000, high 10, low 2, active level high).
//   csr_ writes take effect at once; write only while no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger_unit #(
   parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_start_req,
   input  wire logic                            req_echo_level,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_trigger_out,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   output logic                                 rsp_timed_out,
   output logic [uer_pkg::PULSE_W-1:0]          rsp_pulse_us,
   output logic [uer_pkg::DIST_W-1:0]           rsp_distance_cm,
   input  wire logic                            csr_write_en,
   input  wire logic [uer_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [uer_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import uer_pkg::*;

   uer_cfg_type    cfg_ff;
   logic           in_valid_ff;
   logic           in_start_ff;
   logic           in_echo_ff;
   logic           out_valid_ff;
   uer_result_type out_ff;
   uer_result_type core_result;
   logic           advance;

   // move the held item into the result register when it is empty or being taken
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_us      <= TIMEOUT_RESET;
         cfg_ff.trigger_high_us <= TRIGGER_HIGH_RESET;
         cfg_ff.trigger_low_us  <= TRIGGER_LOW_RESET;
         cfg_ff.active_level    <= ACTIVE_LEVEL_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TIMEOUT: begin
               cfg_ff.timeout_us <= csr_wdata[TIMEOUT_W-1:0];
            end
            CSR_TRIGGER_HIGH: begin
               cfg_ff.trigger_high_us <= csr_wdata[TRIGGER_W-1:0];
            end
            CSR_TRIGGER_LOW: begin
               cfg_ff.trigger_low_us <= csr_wdata[TRIGGER_W-1:0];
            end
            CSR_ACTIVE_LEVEL: begin
               cfg_ff.active_level <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_start_ff <= req_start_req;
         in_echo_ff  <= req_echo_level;
      end
   end

   uer_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .start_req  (in_start_ff),
      .echo_level (in_echo_ff),
      .cfg        (cfg_ff),
      .result     (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_trigger_out = out_ff.trigger_out;
   assign rsp_busy_res    = out_ff.busy_res;
   assign rsp_done_res    = out_ff.done_res;
   assign rsp_timed_out   = out_ff.timed_out;
   assign rsp_pulse_us    = out_ff.pulse_us;
   assign rsp_distance_cm = out_ff.distance_cm;

endmodule

`default_nettype wire

### rtl/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks of the echo ranger result channel, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module uer_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            req_start_req,
   input wire logic                            req_echo_level,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_trigger_out,
   input wire logic                            rsp_busy_res,
   input wire logic                            rsp_done_res,
   input wire logic                            rsp_timed_out,
   input wire logic [uer_pkg::PULSE_W-1:0]     rsp_pulse_us,
   input wire logic [uer_pkg::DIST_W-1:0]      rsp_distance_cm,
   input wire logic                            csr_write_en,
   input wire logic [uer_pkg::CSR_IDX_W-1:0]   csr_index,
   input wire logic [uer_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic unused_inputs;
   assign unused_inputs = req_valid ^ req_ready ^ req_start_req ^ req_echo_level
                          ^ csr_write_en ^ (^csr_index) ^ (^csr_wdata);

   `UER_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pulse_us) && $stable(rsp_done_res), "result item changed while stalled")
   `UER_ASSERT_IMPLY(a_tmo_done, clock, reset, rsp_valid && rsp_timed_out, rsp_done_res && rsp_pulse_us == '0 && rsp_distance_cm == '0, "timeout without done or with nonzero width")
   `UER_ASSERT_IMPLY(a_idle_zero, clock, reset, rsp_valid && !rsp_done_res, rsp_pulse_us == '0 && rsp_distance_cm == '0, "width or distance outside a done item")
   `UER_ASSERT_IMPLY(a_done_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res && !rsp_trigger_out, "done item still busy or triggering")
   `UER_ASSERT_IMPLY(a_trig_busy, clock, reset, rsp_valid && rsp_trigger_out, rsp_busy_res, "trigger high outside a sequence")

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_uer_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_start_req   (req_start_req),
   .req_echo_level  (req_echo_level),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_trigger_out (rsp_trigger_out),
   .rsp_busy_res    (rsp_busy_res),
   .rsp_done_res    (rsp_done_res),
   .rsp_timed_out   (rsp_timed_out),
   .rsp_pulse_us    (rsp_pulse_us),
   .rsp_distance_cm (rsp_distance_cm),
   .csr_write_en    (csr_write_en),
   .csr_index       (csr_index),
   .csr_wdata       (csr_wdata)
);

`default_nettype wire
